// ===== sv/dlmc_pkg.sv =====
// Shared types, constants and encode helpers for the device lifecycle mode controller.
package dlmc_pkg;

  // Highest legal service procedure is PROCEDURE_COUNT - 1 (range 2..16)
  localparam int unsigned PROCEDURE_COUNT = 8;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [3:0] {
    CMD_BOOT_DONE    = 4'd0,
    CMD_MOTOR        = 4'd1,
    CMD_SERVICE      = 4'd2,
    CMD_STANDBY      = 4'd3,
    CMD_RUN          = 4'd4,
    CMD_VERIFY       = 4'd5,
    CMD_COMPLETE     = 4'd6,
    CMD_FAIL         = 4'd7,
    CMD_CANCEL       = 4'd8,
    CMD_UPDATE       = 4'd9,
    CMD_ABORT_UPDATE = 4'd10,
    CMD_FAULT        = 4'd11,
    CMD_CLEAR_FAULT  = 4'd12
  } cmd_t;

  // Device mode state register, one-hot
  typedef enum logic [5:0] {
    MODE_BOOTING   = 6'b000001,
    MODE_STANDBY   = 6'b000010,
    MODE_ACTIVE    = 6'b000100,
    MODE_SERVICING = 6'b001000,
    MODE_UPDATING  = 6'b010000,
    MODE_FAULTED   = 6'b100000
  } mode_t;

  // Dense codes reported on the result beat
  localparam logic [2:0] MODE_CODE_BOOTING   = 3'd0;
  localparam logic [2:0] MODE_CODE_STANDBY   = 3'd1;
  localparam logic [2:0] MODE_CODE_ACTIVE    = 3'd2;
  localparam logic [2:0] MODE_CODE_SERVICING = 3'd3;
  localparam logic [2:0] MODE_CODE_UPDATING  = 3'd4;
  localparam logic [2:0] MODE_CODE_FAULTED   = 3'd5;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_PRECHECK  = 3'd1,
    PH_RUNNING   = 3'd2,
    PH_VERIFYING = 3'd3,
    PH_COMPLETED = 3'd4,
    PH_FAILED    = 3'd5,
    PH_CANCELLED = 3'd6
  } phase_t;

  localparam logic [3:0] MOTOR_NONE   = 4'd0;
  localparam logic [3:0] SERVICE_NONE = 4'd0;

  typedef struct packed {
    mode_t      mode;
    logic [3:0] motor;
    logic [3:0] service;
    phase_t     phase;
  } dev_state_t;

  typedef struct packed {
    cmd_t       command;
    logic [3:0] motor_mode_request;
    logic [3:0] procedure_request;
    logic       faults_cleared;
  } cmd_beat_t;

  function automatic logic [2:0] mode_code(input mode_t mode);
    logic [2:0] code;
    unique case (mode)
      MODE_BOOTING:   code = MODE_CODE_BOOTING;
      MODE_STANDBY:   code = MODE_CODE_STANDBY;
      MODE_ACTIVE:    code = MODE_CODE_ACTIVE;
      MODE_SERVICING: code = MODE_CODE_SERVICING;
      MODE_UPDATING:  code = MODE_CODE_UPDATING;
      MODE_FAULTED:   code = MODE_CODE_FAULTED;
      default:        code = MODE_CODE_BOOTING;
    endcase
    return code;
  endfunction

endpackage

// ===== sv/dlmc_next.sv =====
// Guarded transition logic: next device state and accept flag for one command.
module dlmc_next (
  input  dlmc_pkg::dev_state_t state,
  input  dlmc_pkg::cmd_beat_t  beat,
  output dlmc_pkg::dev_state_t state_next,
  output logic                 accepted
);

  logic in_standby;
  logic in_active;
  logic in_servicing;
  logic in_updating;
  logic in_faulted;
  logic in_booting;
  logic proc_ok;

  assign in_booting   = (state.mode == dlmc_pkg::MODE_BOOTING);
  assign in_standby   = (state.mode == dlmc_pkg::MODE_STANDBY);
  assign in_active    = (state.mode == dlmc_pkg::MODE_ACTIVE);
  assign in_servicing = (state.mode == dlmc_pkg::MODE_SERVICING);
  assign in_updating  = (state.mode == dlmc_pkg::MODE_UPDATING);
  assign in_faulted   = (state.mode == dlmc_pkg::MODE_FAULTED);

  // widen by one bit so a count of 16 still compares correctly
  assign proc_ok = (beat.procedure_request != dlmc_pkg::SERVICE_NONE) &&
                   ({1'b0, beat.procedure_request} < 5'(dlmc_pkg::PROCEDURE_COUNT));

  always_comb begin
    state_next = state;
    accepted   = 1'b0;
    unique case (beat.command)
      dlmc_pkg::CMD_BOOT_DONE: begin
        if (in_booting) begin
          state_next.mode = dlmc_pkg::MODE_STANDBY;
          accepted        = 1'b1;
        end
      end
      dlmc_pkg::CMD_MOTOR: begin
        if ((beat.motor_mode_request != dlmc_pkg::MOTOR_NONE) && (in_standby || in_active)) begin
          state_next = '{dlmc_pkg::MODE_ACTIVE, beat.motor_mode_request,
                         dlmc_pkg::SERVICE_NONE, dlmc_pkg::PH_IDLE};
          accepted   = 1'b1;
        end
      end
      dlmc_pkg::CMD_SERVICE: begin
        if (proc_ok && (in_standby || in_servicing)) begin
          state_next = '{dlmc_pkg::MODE_SERVICING, dlmc_pkg::MOTOR_NONE,
                         beat.procedure_request, dlmc_pkg::PH_PRECHECK};
          accepted   = 1'b1;
        end
      end
      dlmc_pkg::CMD_STANDBY: begin
        if (!in_booting && !in_faulted && !in_updating) begin
          state_next = '{dlmc_pkg::MODE_STANDBY, dlmc_pkg::MOTOR_NONE,
                         dlmc_pkg::SERVICE_NONE, dlmc_pkg::PH_IDLE};
          accepted   = 1'b1;
        end
      end
      dlmc_pkg::CMD_RUN: begin
        if (in_servicing && (state.phase == dlmc_pkg::PH_PRECHECK)) begin
          state_next.phase = dlmc_pkg::PH_RUNNING;
          accepted         = 1'b1;
        end
      end
      dlmc_pkg::CMD_VERIFY: begin
        if (in_servicing && (state.phase == dlmc_pkg::PH_RUNNING)) begin
          state_next.phase = dlmc_pkg::PH_VERIFYING;
          accepted         = 1'b1;
        end
      end
      dlmc_pkg::CMD_COMPLETE: begin
        if (in_servicing && (state.phase == dlmc_pkg::PH_VERIFYING)) begin
          state_next.phase = dlmc_pkg::PH_COMPLETED;
          accepted         = 1'b1;
        end
      end
      dlmc_pkg::CMD_FAIL: begin
        if (in_servicing) begin
          state_next.phase = dlmc_pkg::PH_FAILED;
          accepted         = 1'b1;
        end
      end
      dlmc_pkg::CMD_CANCEL: begin
        if (in_servicing) begin
          state_next.phase = dlmc_pkg::PH_CANCELLED;
          accepted         = 1'b1;
        end
      end
      dlmc_pkg::CMD_UPDATE: begin
        if (in_standby) begin
          state_next = '{dlmc_pkg::MODE_UPDATING, dlmc_pkg::MOTOR_NONE,
                         dlmc_pkg::SERVICE_NONE, dlmc_pkg::PH_IDLE};
          accepted   = 1'b1;
        end
      end
      dlmc_pkg::CMD_ABORT_UPDATE: begin
        if (in_updating) begin
          state_next = '{dlmc_pkg::MODE_STANDBY, dlmc_pkg::MOTOR_NONE,
                         dlmc_pkg::SERVICE_NONE, dlmc_pkg::PH_IDLE};
          accepted   = 1'b1;
        end
      end
      dlmc_pkg::CMD_FAULT: begin
        state_next = '{dlmc_pkg::MODE_FAULTED, dlmc_pkg::MOTOR_NONE,
                       dlmc_pkg::SERVICE_NONE, dlmc_pkg::PH_FAILED};
        accepted   = 1'b1;
      end
      dlmc_pkg::CMD_CLEAR_FAULT: begin
        // motor mode and procedure are kept as they are
        if (beat.faults_cleared && in_faulted) begin
          state_next.mode  = dlmc_pkg::MODE_STANDBY;
          state_next.phase = dlmc_pkg::PH_IDLE;
          accepted         = 1'b1;
        end
      end
      default: begin
        // unused command codes: reject, hold state
      end
    endcase
  end

endmodule

// ===== sv/device_lifecycle_mode_controller.sv =====
// Top level: command input register, guarded mode update and result register.
// A command beat is captured in the input register, passes through the guarded
// transition logic and is registered as a result beat in the result register.
// Throughput: one command per cycle while the result side keeps up; the input and
// result registers sit on either side of the transition logic, so both stream freely.
// Back-pressure on the result side stalls the input register only when both are full.
// Reset (rst, synchronous, active high): booting, no motor mode, no procedure,
// phase idle; both registers empty.
module device_lifecycle_mode_controller (
  input  logic                              clk,
  input  logic                              rst,
  // command beats
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [3:0] command, [7:4] motor_mode_request, [11:8] procedure_request,
  // [12] faults_cleared, [15:13] zero
  input  logic [dlmc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // result beats
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] accepted, [3:1] device_mode, [7:4] motor_mode, [11:8] service_selected,
  // [14:12] phase, [15] zero
  output logic [dlmc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // input register
  logic                in_valid;
  dlmc_pkg::cmd_beat_t in_beat;

  // device state
  dlmc_pkg::dev_state_t state;
  dlmc_pkg::dev_state_t state_next;
  logic                 accepted_next;

  // result register
  logic                             out_valid;
  logic [dlmc_pkg::OUT_TDATA_W-1:0] out_data;

  logic advance;   // input register hands its beat on to the result register
  logic take_in;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  // Capture the command beat; drop the valid when it moves on with nothing behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take_in) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_beat.command            <= dlmc_pkg::cmd_t'(s_axis_tdata[3:0]);
      in_beat.motor_mode_request <= s_axis_tdata[7:4];
      in_beat.procedure_request  <= s_axis_tdata[11:8];
      in_beat.faults_cleared     <= s_axis_tdata[12];
    end
  end

  dlmc_next u_next (
    .state      (state),
    .beat       (in_beat),
    .state_next (state_next),
    .accepted   (accepted_next)
  );

  // Commit the transition only when the result has somewhere to go
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{dlmc_pkg::MODE_BOOTING, dlmc_pkg::MOTOR_NONE,
                 dlmc_pkg::SERVICE_NONE, dlmc_pkg::PH_IDLE};
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register: hold while the downstream stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {1'b0, state_next.phase, state_next.service, state_next.motor,
                   dlmc_pkg::mode_code(state_next.mode), accepted_next};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule
